// File: hdl/plhs_pkg.sv
// plhs_pkg: shared types, register map and arctangent table for the halo scatter block
// no dependencies; imported by every module of the block
`default_nettype none

package plhs_pkg;

  localparam int TabLen = 24;

  typedef enum logic [2:0] {
    RA_POS_X = 3'd0,
    RA_POS_Y = 3'd1,
    RA_POS_Z = 3'd2,
    RA_HALO  = 3'd3,
    RA_RED   = 3'd4,
    RA_GREEN = 3'd5,
    RA_BLUE  = 3'd6
  } reg_addr_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [30:0]        hit_distance;
  } ray_t;

  typedef struct packed {
    logic signed [36:0] t0;
    logic [30:0]        seg_len;
    logic [3:0]         shift;
  } geo_side_t;

  typedef struct packed {
    logic [40:0] d0;
    logic        hits;
  } ang_side_t;

  typedef struct packed {
    logic [45:0] g;
    logic        sat;
    logic        hits;
  } gain_t;

  // atan(2^-i) in Q.30 radians, truncated
  function automatic logic [29:0] atan_tab(input int i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd843314856;
      1:  v = 30'd497837829;
      2:  v = 30'd263043836;
      3:  v = 30'd133525158;
      4:  v = 30'd67021686;
      5:  v = 30'd33543515;
      6:  v = 30'd16775850;
      7:  v = 30'd8388437;
      8:  v = 30'd4194282;
      9:  v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/plhs_ray_if.sv
// plhs_ray_if: ray segment request channel, valid/ready with payload
// no dependencies
`default_nettype none

interface plhs_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic [30:0]        hit_distance;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  hit_distance, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                hit_distance, output ready);
endinterface

`default_nettype wire

// File: hdl/plhs_scatter_if.sv
// plhs_scatter_if: scattered light result channel, valid/ready with payload
// no dependencies
`default_nettype none

interface plhs_scatter_if;
  logic        valid;
  logic        ready;
  logic [15:0] scatter_red;
  logic [15:0] scatter_green;
  logic [15:0] scatter_blue;
  logic        ray_hits_light;

  modport source (output valid, scatter_red, scatter_green, scatter_blue, ray_hits_light,
                  input ready);
  modport sink (input valid, scatter_red, scatter_green, scatter_blue, ray_hits_light,
                output ready);
endinterface

`default_nettype wire

// File: hdl/plhs_geom.sv
// plhs_geom: eight-stage ray geometry, t0, perpendicular offset and squared distance
// depends on plhs_pkg
`default_nettype none

module plhs_geom (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  plhs_pkg::ray_t     ray,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               out_valid,
  output logic [63:0]        sum_sq,
  output plhs_pkg::geo_side_t side
);
  import plhs_pkg::*;

  logic [7:0] vld;

  logic signed [32:0] s1_lx, s1_ly, s1_lz, s2_lx, s2_ly, s2_lz;
  logic signed [32:0] s3_lx, s3_ly, s3_lz, s4_lx, s4_ly, s4_lz;
  logic signed [15:0] s1_dx, s1_dy, s1_dz, s2_dx, s2_dy, s2_dz, s3_dx, s3_dy, s3_dz;
  logic [30:0]        s1_dist, s2_dist, s3_dist, s4_dist, s5_dist, s6_dist, s7_dist;
  logic signed [48:0] s2_mx, s2_my, s2_mz;
  logic signed [36:0] s3_t0, s4_t0, s5_t0, s6_t0, s7_t0;
  logic signed [52:0] s4_qx, s4_qy, s4_qz;
  logic signed [39:0] px, py, pz;
  logic [39:0]        s5_ax, s5_ay, s5_az;
  logic [39:0]        m6;
  logic [3:0]         k6, s6_k, s7_k;
  logic [30:0]        s6_bx, s6_by, s6_bz;
  logic [61:0]        s7_sx, s7_sy, s7_sz;
  logic [63:0]        s8_sum;
  geo_side_t          s8_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:0], in_valid};
    end
  end

  always_comb begin
    px = 40'(s4_lx) - 40'(s4_qx >>> 14);
    py = 40'(s4_ly) - 40'(s4_qy >>> 14);
    pz = 40'(s4_lz) - 40'(s4_qz >>> 14);
  end

  // shift that brings the largest magnitude below 2^31
  always_comb begin
    m6 = s5_ax;
    if (s5_ay > m6) m6 = s5_ay;
    if (s5_az > m6) m6 = s5_az;
    k6 = '0;
    for (int b = 0; b < 9; b++) begin
      if (m6[31 + b]) k6 = 4'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_lx   <= 33'(pos_x) - 33'(ray.origin_x);
      s1_ly   <= 33'(pos_y) - 33'(ray.origin_y);
      s1_lz   <= 33'(pos_z) - 33'(ray.origin_z);
      s1_dx   <= ray.dir_x;
      s1_dy   <= ray.dir_y;
      s1_dz   <= ray.dir_z;
      s1_dist <= ray.hit_distance;

      s2_mx   <= 49'(s1_lx) * 49'(s1_dx);
      s2_my   <= 49'(s1_ly) * 49'(s1_dy);
      s2_mz   <= 49'(s1_lz) * 49'(s1_dz);
      s2_lx   <= s1_lx;
      s2_ly   <= s1_ly;
      s2_lz   <= s1_lz;
      s2_dx   <= s1_dx;
      s2_dy   <= s1_dy;
      s2_dz   <= s1_dz;
      s2_dist <= s1_dist;

      s3_t0   <= 37'((51'(s2_mx) + 51'(s2_my) + 51'(s2_mz)) >>> 14);
      s3_lx   <= s2_lx;
      s3_ly   <= s2_ly;
      s3_lz   <= s2_lz;
      s3_dx   <= s2_dx;
      s3_dy   <= s2_dy;
      s3_dz   <= s2_dz;
      s3_dist <= s2_dist;

      s4_qx   <= 53'(s3_dx) * 53'(s3_t0);
      s4_qy   <= 53'(s3_dy) * 53'(s3_t0);
      s4_qz   <= 53'(s3_dz) * 53'(s3_t0);
      s4_lx   <= s3_lx;
      s4_ly   <= s3_ly;
      s4_lz   <= s3_lz;
      s4_t0   <= s3_t0;
      s4_dist <= s3_dist;

      s5_ax   <= px[39] ? (~px + 40'd1) : px;
      s5_ay   <= py[39] ? (~py + 40'd1) : py;
      s5_az   <= pz[39] ? (~pz + 40'd1) : pz;
      s5_t0   <= s4_t0;
      s5_dist <= s4_dist;

      s6_bx   <= 31'(s5_ax >> k6);
      s6_by   <= 31'(s5_ay >> k6);
      s6_bz   <= 31'(s5_az >> k6);
      s6_k    <= k6;
      s6_t0   <= s5_t0;
      s6_dist <= s5_dist;

      s7_sx   <= 62'(s6_bx) * 62'(s6_bx);
      s7_sy   <= 62'(s6_by) * 62'(s6_by);
      s7_sz   <= 62'(s6_bz) * 62'(s6_bz);
      s7_k    <= s6_k;
      s7_t0   <= s6_t0;
      s7_dist <= s6_dist;

      s8_sum          <= 64'(s7_sx) + 64'(s7_sy) + 64'(s7_sz);
      s8_side.t0      <= s7_t0;
      s8_side.seg_len <= s7_dist;
      s8_side.shift   <= s7_k;
    end
  end

  assign out_valid = vld[7];
  assign sum_sq    = s8_sum;
  assign side      = s8_side;

endmodule

`default_nettype wire

// File: hdl/plhs_isqrt.sv
// plhs_isqrt: 64-bit truncating square root, one result bit per pipeline stage
// depends on plhs_pkg
`default_nettype none

module plhs_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [63:0]         num,
  input  plhs_pkg::geo_side_t in_side,
  output logic                out_valid,
  output logic [31:0]         root,
  output plhs_pkg::geo_side_t out_side
);
  import plhs_pkg::*;

  localparam int Steps = 32;

  logic [63:0] rem_in  [Steps];
  logic [63:0] acc_in  [Steps];
  geo_side_t   side_in [Steps];
  logic        vld_in  [Steps];
  logic [63:0] rem_stg  [Steps];
  logic [63:0] acc_stg  [Steps];
  geo_side_t   side_stg [Steps];
  logic        vld_stg  [Steps];

  for (genvar j = 0; j < Steps; j++) begin : g_stage
    localparam logic [63:0] Bit = 64'(1) << (62 - 2 * j);
    logic [64:0] trial;
    logic        take;

    if (j == 0) begin : g_first
      assign rem_in[j]  = num;
      assign acc_in[j]  = '0;
      assign side_in[j] = in_side;
      assign vld_in[j]  = in_valid;
    end else begin : g_next
      assign rem_in[j]  = rem_stg[j-1];
      assign acc_in[j]  = acc_stg[j-1];
      assign side_in[j] = side_stg[j-1];
      assign vld_in[j]  = vld_stg[j-1];
    end

    assign trial = {1'b0, acc_in[j]} + {1'b0, Bit};
    assign take  = ({1'b0, rem_in[j]} >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_stg[j] <= 1'b0;
      end else if (en) begin
        vld_stg[j] <= vld_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_stg[j]  <= take ? (rem_in[j] - trial[63:0]) : rem_in[j];
        acc_stg[j]  <= take ? ((acc_in[j] >> 1) + Bit) : (acc_in[j] >> 1);
        side_stg[j] <= side_in[j];
      end
    end
  end

  assign out_valid = vld_stg[Steps-1];
  assign root      = acc_stg[Steps-1][31:0];
  assign out_side  = side_stg[Steps-1];

endmodule

`default_nettype wire

// File: hdl/plhs_cordic.sv
// plhs_cordic: d0, operand normalization and two CORDIC vectoring lanes for the angle span
// depends on plhs_pkg
`default_nettype none

module plhs_cordic #(
  parameter int STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [31:0]         root,
  input  plhs_pkg::geo_side_t in_side,
  output logic                out_valid,
  output logic [31:0]         span,
  output plhs_pkg::ang_side_t out_side
);
  import plhs_pkg::*;

  function automatic logic [5:0] bit_len(input logic [40:0] v);
    logic [5:0] n;
    n = '0;
    for (int b = 0; b < 41; b++) begin
      if (v[b]) n = 6'(b + 1);
    end
    return n;
  endfunction

  // stage 1: d0 and the two arctangent numerators
  logic               v1, v2, v3, vo;
  ang_side_t          a1, a2, a3, ao;
  logic signed [37:0] y1 [2];
  logic signed [37:0] y2 [2];
  logic signed [6:0]  sh2 [2];
  logic [37:0]        ymag [2];
  logic [40:0]        mx [2];
  logic signed [33:0] x3 [2];
  logic signed [33:0] y3 [2];
  logic [31:0]        span_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ymag[l] = y1[l][37] ? (~y1[l] + 38'd1) : y1[l];
      mx[l]   = (41'(ymag[l]) > a1.d0) ? 41'(ymag[l]) : a1.d0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1.d0   <= 41'(root) << in_side.shift;
      a1.hits <= (root == '0);
      y1[0]   <= $signed({7'd0, in_side.seg_len}) - 38'(in_side.t0);
      y1[1]   <= -38'(in_side.t0);

      a2 <= a1;
      for (int l = 0; l < 2; l++) begin
        y2[l]  <= y1[l];
        sh2[l] <= 7'sd30 - $signed({1'b0, bit_len(mx[l])});
      end

      a3 <= a2;
      for (int l = 0; l < 2; l++) begin
        if (!sh2[l][6]) begin
          x3[l] <= 34'(a2.d0 << sh2[l][4:0]);
          y3[l] <= 34'(y2[l] <<< sh2[l][4:0]);
        end else begin
          x3[l] <= 34'(a2.d0 >> 5'(-sh2[l]));
          y3[l] <= 34'(y2[l] >>> 5'(-sh2[l]));
        end
      end
    end
  end

  // vectoring iterations, one per stage
  logic signed [33:0] x_in  [STEPS][2];
  logic signed [33:0] y_in  [STEPS][2];
  logic signed [31:0] z_in  [STEPS][2];
  ang_side_t          s_in  [STEPS];
  logic               v_in  [STEPS];
  logic signed [33:0] x_stg [STEPS][2];
  logic signed [33:0] y_stg [STEPS][2];
  logic signed [31:0] z_stg [STEPS][2];
  ang_side_t          s_stg [STEPS];
  logic               v_stg [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [31:0] Ang = 32'(atan_tab(i));

    if (i == 0) begin : g_first
      assign x_in[i][0] = x3[0];
      assign x_in[i][1] = x3[1];
      assign y_in[i][0] = y3[0];
      assign y_in[i][1] = y3[1];
      assign z_in[i][0] = '0;
      assign z_in[i][1] = '0;
      assign s_in[i]    = a3;
      assign v_in[i]    = v3;
    end else begin : g_next
      assign x_in[i][0] = x_stg[i-1][0];
      assign x_in[i][1] = x_stg[i-1][1];
      assign y_in[i][0] = y_stg[i-1][0];
      assign y_in[i][1] = y_stg[i-1][1];
      assign z_in[i][0] = z_stg[i-1][0];
      assign z_in[i][1] = z_stg[i-1][1];
      assign s_in[i]    = s_stg[i-1];
      assign v_in[i]    = v_stg[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_stg[i] <= 1'b0;
      end else if (en) begin
        v_stg[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_stg[i] <= s_in[i];
        for (int l = 0; l < 2; l++) begin
          if (y_in[i][l] > 0) begin
            x_stg[i][l] <= x_in[i][l] + (y_in[i][l] >>> i);
            y_stg[i][l] <= y_in[i][l] - (x_in[i][l] >>> i);
            z_stg[i][l] <= z_in[i][l] + Ang;
          end else begin
            x_stg[i][l] <= x_in[i][l] - (y_in[i][l] >>> i);
            y_stg[i][l] <= y_in[i][l] + (x_in[i][l] >>> i);
            z_stg[i][l] <= z_in[i][l] - Ang;
          end
        end
      end
    end
  end

  logic signed [32:0] diff;
  assign diff = 33'(z_stg[STEPS-1][0]) - 33'(z_stg[STEPS-1][1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= v_stg[STEPS-1];
    end
  end

  // a negative span counts as zero
  always_ff @(posedge clk) begin
    if (en) begin
      span_o <= diff[32] ? '0 : diff[31:0];
      ao     <= s_stg[STEPS-1];
    end
  end

  assign out_valid = vo;
  assign span      = span_o;
  assign out_side  = ao;

endmodule

`default_nettype wire

// File: hdl/plhs_div.sv
// plhs_div: halo times span, then restoring division by d0, one quotient bit per stage
// depends on plhs_pkg
`default_nettype none

module plhs_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [30:0]         halo,
  input  logic [31:0]         span,
  input  plhs_pkg::ang_side_t in_side,
  output logic                out_valid,
  output plhs_pkg::gain_t     gain
);
  import plhs_pkg::*;

  localparam int QBits = 46;

  logic        v1, v2;
  logic [62:0] prod1;
  ang_side_t   a1, a2;
  logic [40:0] rem2;
  logic [45:0] num2;
  logic        sat2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // quotient at or above 2^46 saturates every channel whose colour is nonzero
  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= 63'(halo) * 63'(span);
      a1    <= in_side;
      sat2  <= (41'(prod1[62:46]) >= a1.d0);
      rem2  <= 41'(prod1[62:46]);
      num2  <= prod1[45:0];
      a2    <= a1;
    end
  end

  logic [40:0] rem_in  [QBits];
  logic [45:0] num_in  [QBits];
  logic [45:0] quo_in  [QBits];
  ang_side_t   side_in [QBits];
  logic        sat_in  [QBits];
  logic        vld_in  [QBits];
  logic [40:0] rem_stg  [QBits];
  logic [45:0] num_stg  [QBits];
  logic [45:0] quo_stg  [QBits];
  ang_side_t   side_stg [QBits];
  logic        sat_stg  [QBits];
  logic        vld_stg  [QBits];

  for (genvar s = 0; s < QBits; s++) begin : g_bit
    logic [41:0] trial;
    logic        ge;

    if (s == 0) begin : g_first
      assign rem_in[s]  = rem2;
      assign num_in[s]  = num2;
      assign quo_in[s]  = '0;
      assign side_in[s] = a2;
      assign sat_in[s]  = sat2;
      assign vld_in[s]  = v2;
    end else begin : g_next
      assign rem_in[s]  = rem_stg[s-1];
      assign num_in[s]  = num_stg[s-1];
      assign quo_in[s]  = quo_stg[s-1];
      assign side_in[s] = side_stg[s-1];
      assign sat_in[s]  = sat_stg[s-1];
      assign vld_in[s]  = vld_stg[s-1];
    end

    assign trial = {rem_in[s], num_in[s][45]};
    assign ge    = (trial >= {1'b0, side_in[s].d0});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_stg[s] <= 1'b0;
      end else if (en) begin
        vld_stg[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_stg[s]  <= ge ? 41'(trial - {1'b0, side_in[s].d0}) : trial[40:0];
        num_stg[s]  <= num_in[s] << 1;
        quo_stg[s]  <= {quo_in[s][44:0], ge};
        side_stg[s] <= side_in[s];
        sat_stg[s]  <= sat_in[s];
      end
    end
  end

  assign out_valid = vld_stg[QBits-1];
  assign gain.g    = quo_stg[QBits-1];
  assign gain.sat  = sat_stg[QBits-1];
  assign gain.hits = side_stg[QBits-1].hits;

endmodule

`default_nettype wire

// File: hdl/point_light_halo_scatter.sv
// point_light_halo_scatter: point light halo scattering along a ray segment, top level
// depends on plhs_pkg, plhs_ray_if, plhs_scatter_if, plhs_geom, plhs_isqrt, plhs_cordic, plhs_div
//
//   channel   direction  handshake      payload
//   ray       in         valid/ready    origin_x/y/z, dir_x/y/z, hit_distance
//   scatter   out        valid/ready    scatter_red/green/blue, ray_hits_light
//   apb       in         psel/penable   light position, halo strength, colour
//
// one request per cycle sustained while scatter.ready does not stall a valid result;
// the pipeline includes the 32-stage square root, the CORDIC stages and the 46-stage quotient
// synchronous reset clears the valid bits and sets the APB registers to their defaults
// a stalled result holds the whole pipeline in place; ray.ready drops only then
`default_nettype none

module point_light_halo_scatter #(
  parameter int ATAN_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  plhs_ray_if.sink    ray,
  plhs_scatter_if.source scatter,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import plhs_pkg::*;

  logic signed [31:0] light_pos_x, light_pos_y, light_pos_z;
  logic [30:0]        halo_strength;
  logic [15:0]        light_red, light_green, light_blue;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_pos_x   <= '0;
      light_pos_y   <= '0;
      light_pos_z   <= '0;
      halo_strength <= '0;
      light_red     <= 16'hFFFF;
      light_green   <= 16'hFFFF;
      light_blue    <= 16'hFFFF;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        RA_POS_X: light_pos_x   <= pwdata;
        RA_POS_Y: light_pos_y   <= pwdata;
        RA_POS_Z: light_pos_z   <= pwdata;
        RA_HALO:  halo_strength <= pwdata[30:0];
        RA_RED:   light_red     <= pwdata[15:0];
        RA_GREEN: light_green   <= pwdata[15:0];
        RA_BLUE:  light_blue    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RA_POS_X: prdata = light_pos_x;
      RA_POS_Y: prdata = light_pos_y;
      RA_POS_Z: prdata = light_pos_z;
      RA_HALO:  prdata = {1'b0, halo_strength};
      RA_RED:   prdata = {16'd0, light_red};
      RA_GREEN: prdata = {16'd0, light_green};
      RA_BLUE:  prdata = {16'd0, light_blue};
      default:  prdata = '0;
    endcase
  end

  // pipeline advance
  logic en;
  logic out_valid;
  assign en        = !out_valid || scatter.ready;
  assign ray.ready = en;

  ray_t ray_in;
  assign ray_in.origin_x     = ray.origin_x;
  assign ray_in.origin_y     = ray.origin_y;
  assign ray_in.origin_z     = ray.origin_z;
  assign ray_in.dir_x        = ray.dir_x;
  assign ray_in.dir_y        = ray.dir_y;
  assign ray_in.dir_z        = ray.dir_z;
  assign ray_in.hit_distance = ray.hit_distance;

  logic        geo_valid, sq_valid, ang_valid, div_valid;
  logic [63:0] sum_sq;
  logic [31:0] root, span;
  geo_side_t   geo_side, sq_side;
  ang_side_t   ang_side;
  gain_t       gain;

  plhs_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ray.valid),
    .ray       (ray_in),
    .pos_x     (light_pos_x),
    .pos_y     (light_pos_y),
    .pos_z     (light_pos_z),
    .out_valid (geo_valid),
    .sum_sq    (sum_sq),
    .side      (geo_side)
  );

  plhs_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (geo_valid),
    .num       (sum_sq),
    .in_side   (geo_side),
    .out_valid (sq_valid),
    .root      (root),
    .out_side  (sq_side)
  );

  plhs_cordic #(.STEPS(ATAN_STEPS)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .root      (root),
    .in_side   (sq_side),
    .out_valid (ang_valid),
    .span      (span),
    .out_side  (ang_side)
  );

  plhs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ang_valid),
    .halo      (halo_strength),
    .span      (span),
    .in_side   (ang_side),
    .out_valid (div_valid),
    .gain      (gain)
  );

  function automatic logic [15:0] ch_val(input logic [15:0] c, input logic [61:0] p,
                                         input logic sat);
    logic [15:0] v;
    if (c == '0) v = '0;
    else if (sat || (|p[61:46])) v = 16'hFFFF;
    else v = p[45:30];
    return v;
  endfunction

  logic        c_valid;
  logic [61:0] c_red, c_green, c_blue;
  logic        c_sat, c_hits;
  logic [15:0] out_red, out_green, out_blue;
  logic        out_hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      c_valid   <= div_valid;
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_red   <= 62'(light_red) * 62'(gain.g);
      c_green <= 62'(light_green) * 62'(gain.g);
      c_blue  <= 62'(light_blue) * 62'(gain.g);
      c_sat   <= gain.sat;
      c_hits  <= gain.hits;
      if (halo_strength == '0) begin
        out_red   <= '0;
        out_green <= '0;
        out_blue  <= '0;
        out_hits  <= 1'b0;
      end else if (c_hits) begin
        out_red   <= '0;
        out_green <= '0;
        out_blue  <= '0;
        out_hits  <= 1'b1;
      end else begin
        out_red   <= ch_val(light_red, c_red, c_sat);
        out_green <= ch_val(light_green, c_green, c_sat);
        out_blue  <= ch_val(light_blue, c_blue, c_sat);
        out_hits  <= 1'b0;
      end
    end
  end

  assign scatter.valid          = out_valid;
  assign scatter.scatter_red    = out_red;
  assign scatter.scatter_green  = out_green;
  assign scatter.scatter_blue   = out_blue;
  assign scatter.ray_hits_light = out_hits;

  a_hits_black: assert property (@(posedge clk) disable iff (rst)
    scatter.valid && scatter.ray_hits_light |->
      scatter.scatter_red == '0 && scatter.scatter_green == '0 && scatter.scatter_blue == '0)
    else $error("light hit with nonzero colour");

  a_halo_off: assert property (@(posedge clk) disable iff (rst)
    scatter.valid && halo_strength == '0 |->
      !scatter.ray_hits_light && scatter.scatter_red == '0 &&
      scatter.scatter_green == '0 && scatter.scatter_blue == '0)
    else $error("halo off but result not black");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !scatter.valid |-> ray.ready)
    else $error("pipeline stalled with empty output");

endmodule

`default_nettype wire
